// ===== sv/npl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the nearest plane point labeler.
// Used by npl_dist, nearest_plane_point_labeler and the bench; depends on nothing.
package npl_pkg;

    localparam int CNT_W      = 5;
    localparam int SUM_W      = 50;
    localparam int DIST_W     = 31;
    localparam int RND_SH     = 14;
    localparam int MAX_PLANES = 16;

    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] LIMIT_RESET  = 31'd6554;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic REG_PLANE_COUNT    = 1'b0;
    localparam logic REG_DISTANCE_LIMIT = 1'b1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] d;
    } plane_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  idx;
        logic [DIST_W-1:0] gap;
    } dist_t;

endpackage

// ===== sv/npl_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module npl_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/npl_dist.sv =====
`timescale 1ns / 1ps
// Point to plane distance pipeline: products, sum, absolute value and rounding.
// Depends on npl_pkg.
module npl_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [npl_pkg::CNT_W-1:0]     in_idx,
    input  npl_pkg::plane_t               plane,
    input  npl_pkg::point_t               point,
    output npl_pkg::dist_t                result,
    output logic                          busy
);

    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic [npl_pkg::CNT_W-1:0]      i1_reg;
    logic [npl_pkg::CNT_W-1:0]      i2_reg;
    logic [npl_pkg::CNT_W-1:0]      i3_reg;
    logic signed [47:0]             px_reg;
    logic signed [47:0]             py_reg;
    logic signed [47:0]             pz_reg;
    logic signed [31:0]             d_reg;
    logic signed [npl_pkg::SUM_W-1:0] sum_reg;
    logic [npl_pkg::DIST_W-1:0]     dist_reg;

    logic signed [47:0]             px_next;
    logic signed [47:0]             py_next;
    logic signed [47:0]             pz_next;
    logic signed [npl_pkg::SUM_W-1:0] sum_next;
    logic [npl_pkg::SUM_W-1:0]      mag;
    logic [npl_pkg::SUM_W-1:0]      rnd;
    logic [npl_pkg::SUM_W-npl_pkg::RND_SH-1:0] q;
    logic [npl_pkg::DIST_W-1:0]     dist_next;

    assign px_next = plane.nx * point.x;
    assign py_next = plane.ny * point.y;
    assign pz_next = plane.nz * point.z;

    assign sum_next = {{2{px_reg[47]}}, px_reg} + {{2{py_reg[47]}}, py_reg}
                    + {{2{pz_reg[47]}}, pz_reg}
                    + {{4{d_reg[31]}}, d_reg, {npl_pkg::RND_SH{1'b0}}};

    always_comb
    begin
        mag = sum_reg[npl_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        rnd = mag + (npl_pkg::SUM_W)'(1 << (npl_pkg::RND_SH - 1));
        q   = rnd[npl_pkg::SUM_W-1:npl_pkg::RND_SH];
        if (|q[npl_pkg::SUM_W-npl_pkg::RND_SH-1:npl_pkg::DIST_W])
        begin
            dist_next = npl_pkg::DIST_MAX;
        end
        else
        begin
            dist_next = q[npl_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg   <= in_idx;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
        d_reg    <= plane.d;
        i2_reg   <= i1_reg;
        sum_reg  <= sum_next;
        i3_reg   <= i2_reg;
        dist_reg <= dist_next;
    end

    assign result.valid = v3_reg;
    assign result.idx   = i3_reg;
    assign result.gap   = dist_reg;
    assign busy         = v1_reg || v2_reg || v3_reg;

endmodule

// ===== sv/nearest_plane_point_labeler.sv =====
`timescale 1ns / 1ps
// A load word writes its table entry at acceptance and gives no result. A classify word
// reads n entries, n being plane_count clamped to the table depth, one entry read per
// cycle, then drains the distance pipeline and gives its result (no reads when n is 0).
// One word at a time: a classify holds in_stall until its result is registered, longer
// while the previous result waits on out_stall. Reset clears control state and
// plane_count and sets the limit to LIMIT_RESET; the table holds garbage until loaded.
module nearest_plane_point_labeler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_index,
    input  logic [npl_pkg::DIST_W-1:0]    wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [3:0]                    plane_index,
    input  logic signed [15:0]            normal_x,
    input  logic signed [15:0]            normal_y,
    input  logic signed [15:0]            normal_z,
    input  logic signed [31:0]            plane_offset,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [3:0]                    nearest_plane,
    output logic                          labeled,
    output logic [npl_pkg::DIST_W-1:0]    best_distance
);

    localparam int AW = (npl_pkg::MAX_PLANES > 1) ? $clog2(npl_pkg::MAX_PLANES) : 1;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [npl_pkg::CNT_W-1:0]     count_reg;
    logic [npl_pkg::CNT_W-1:0]     count_next;
    logic [npl_pkg::DIST_W-1:0]    limit_reg;
    logic [npl_pkg::DIST_W-1:0]    limit_next;
    logic [npl_pkg::CNT_W-1:0]     n_reg;
    logic [npl_pkg::CNT_W-1:0]     n_next;
    logic [npl_pkg::CNT_W-1:0]     k_reg;
    logic [npl_pkg::CNT_W-1:0]     k_next;
    logic [npl_pkg::DIST_W-1:0]    best_reg;
    logic [npl_pkg::DIST_W-1:0]    best_next;
    logic [npl_pkg::CNT_W-1:0]     best_idx_reg;
    logic [npl_pkg::CNT_W-1:0]     best_idx_next;
    logic                          rd_valid_reg;
    logic                          rd_valid_next;
    logic [npl_pkg::CNT_W-1:0]     rd_idx_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [3:0]                    out_idx_reg;
    logic [3:0]                    out_idx_next;
    logic                          out_lab_reg;
    logic                          out_lab_next;
    logic [npl_pkg::DIST_W-1:0]    out_dist_reg;
    logic [npl_pkg::DIST_W-1:0]    out_dist_next;
    npl_pkg::point_t               point_reg;

    logic                          in_acc;
    logic                          ram_we;
    logic                          issue;
    logic                          out_free;
    logic                          dist_busy;
    npl_pkg::plane_t               wr_plane;
    npl_pkg::plane_t               rd_plane;
    npl_pkg::dist_t                dres;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != npl_pkg::ST_IDLE);
    assign ram_we   = in_acc && (command == npl_pkg::CMD_LOAD)
                      && (32'(plane_index) < npl_pkg::MAX_PLANES);
    assign issue    = (state_reg == npl_pkg::ST_RUN);
    assign out_free = !out_valid_reg || !out_stall;

    assign wr_plane.nx = normal_x;
    assign wr_plane.ny = normal_y;
    assign wr_plane.nz = normal_z;
    assign wr_plane.d  = plane_offset;

    npl_ram #(
        .WIDTH ($bits(npl_pkg::plane_t)),
        .DEPTH (npl_pkg::MAX_PLANES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(plane_index)),
        .wdata (wr_plane),
        .raddr (AW'(k_reg)),
        .rdata (rd_plane)
    );

    npl_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .plane    (rd_plane),
        .point    (point_reg),
        .result   (dres),
        .busy     (dist_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        limit_next     = limit_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        rd_valid_next  = issue;
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_lab_next   = out_lab_reg;
        out_dist_next  = out_dist_reg;

        if (wr_en)
        begin
            unique case (wr_index)
                npl_pkg::REG_PLANE_COUNT:    count_next = wr_data[npl_pkg::CNT_W-1:0];
                npl_pkg::REG_DISTANCE_LIMIT: limit_next = wr_data;
                default:                     limit_next = limit_reg;
            endcase
        end

        if (dres.valid && ((dres.gap < best_reg) || (dres.idx == '0)))
        begin
            best_next     = dres.gap;
            best_idx_next = dres.idx;
        end

        unique case (state_reg)
            npl_pkg::ST_IDLE:
            begin
                if (in_acc && (command == npl_pkg::CMD_CLASSIFY))
                begin
                    if (32'(count_reg) > npl_pkg::MAX_PLANES)
                    begin
                        n_next = npl_pkg::CNT_W'(npl_pkg::MAX_PLANES);
                    end
                    else
                    begin
                        n_next = count_reg;
                    end
                    k_next        = '0;
                    best_next     = npl_pkg::DIST_MAX;
                    best_idx_next = '0;
                    state_next    = (count_reg == '0) ? npl_pkg::ST_DONE : npl_pkg::ST_RUN;
                end
            end
            npl_pkg::ST_RUN:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = npl_pkg::ST_DRAIN;
                end
            end
            npl_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !dist_busy)
                begin
                    state_next = npl_pkg::ST_DONE;
                end
            end
            npl_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = best_idx_reg[3:0];
                    out_lab_next   = (n_reg != '0) && (best_reg <= limit_reg);
                    out_dist_next  = best_reg;
                    state_next     = npl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = npl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= npl_pkg::ST_IDLE;
            count_reg     <= '0;
            limit_reg     <= npl_pkg::LIMIT_RESET;
            n_reg         <= '0;
            k_reg         <= '0;
            best_reg      <= npl_pkg::DIST_MAX;
            best_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= k_reg;
        out_idx_reg  <= out_idx_next;
        out_lab_reg  <= out_lab_next;
        out_dist_reg <= out_dist_next;
        if (in_acc)
        begin
            point_reg.x <= point_x;
            point_reg.y <= point_y;
            point_reg.z <= point_z;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nearest_plane = out_idx_reg;
    assign labeled       = out_lab_reg;
    assign best_distance = out_dist_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nearest_plane_point_labeler: queue-fed word driver, result monitor
// and an in-bench plane table with nearest distance predictor. Depends on npl_pkg and the RTL.
module tb;

    localparam int PLANES = 16;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic               cmd;
        logic [3:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] ofs;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } word_t;

    typedef struct packed {
        logic [3:0]                 plane;
        logic                       hit;
        logic [npl_pkg::DIST_W-1:0] gap;
    } label_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic wr_index = npl_pkg::REG_PLANE_COUNT;
    logic [npl_pkg::DIST_W-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic command = npl_pkg::CMD_LOAD;
    logic [3:0] plane_index = '0;
    logic signed [15:0] normal_x = '0;
    logic signed [15:0] normal_y = '0;
    logic signed [15:0] normal_z = '0;
    logic signed [31:0] plane_offset = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] nearest_plane;
    logic labeled;
    logic [npl_pkg::DIST_W-1:0] best_distance;

    word_t  pending[$];
    word_t  cur_word;
    word_t  planned[PLANES];
    word_t  planes_held[PLANES];
    label_t label_queue[$];

    logic [npl_pkg::CNT_W-1:0]  cfg_count = '0;
    logic [npl_pkg::DIST_W-1:0] cfg_limit = npl_pkg::LIMIT_RESET;

    int  fails = 0;
    int  words_sent = 0;
    int  points_checked = 0;
    int  labeled_seen = 0;
    int  settings_run = 1;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_reqs = 0;
    int  hold_served = 0;
    bit  calm = 1'b0;

    nearest_plane_point_labeler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .plane_index  (plane_index),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .plane_offset (plane_offset),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .nearest_plane(nearest_plane),
        .labeled      (labeled),
        .best_distance(best_distance)
    );

    always #5 clk = ~clk;

    function automatic logic [npl_pkg::DIST_W-1:0] plane_gap(word_t p, word_t q);
        longint s;
        longint unsigned mag;
        longint unsigned rnd;
        s = longint'(p.nx) * longint'(q.px) + longint'(p.ny) * longint'(q.py)
          + longint'(p.nz) * longint'(q.pz) + longint'(p.ofs) * 64'sd16384;
        mag = (s < 0) ? -s : s;
        rnd = (mag + 64'd8192) >> npl_pkg::RND_SH;
        return (rnd > npl_pkg::DIST_MAX) ? npl_pkg::DIST_MAX : rnd[npl_pkg::DIST_W-1:0];
    endfunction

    function automatic void accept_word(word_t w);
        label_t r;
        int n;
        logic [npl_pkg::DIST_W-1:0] d;
        logic found;
        if (w.cmd == npl_pkg::CMD_LOAD) begin
            planes_held[w.idx] = w;
            return;
        end
        n = (int'(cfg_count) > PLANES) ? PLANES : int'(cfg_count);
        r.plane = '0;
        r.gap = npl_pkg::DIST_MAX;
        found = 1'b0;
        for (int k = 0; k < n; k++) begin
            d = plane_gap(planes_held[4'(k)], w);
            if (!found || d < r.gap) begin
                r.gap = d;
                r.plane = 4'(k);
                found = 1'b1;
            end
        end
        r.hit = found && (r.gap <= cfg_limit);
        label_queue = {label_queue, r};
    endfunction

    always @(posedge clk or negedge rst_n) begin : drive_words
        logic moved;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            moved = in_valid && !in_stall;
            if (moved) begin
                accept_word(cur_word);
                words_sent++;
            end
            if (!in_valid || moved) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end else begin
                    cur_word = pending.pop_front();
                    command      <= cur_word.cmd;
                    plane_index  <= cur_word.idx;
                    normal_x     <= cur_word.nx;
                    normal_y     <= cur_word.ny;
                    normal_z     <= cur_word.nz;
                    plane_offset <= cur_word.ofs;
                    point_x      <= cur_word.px;
                    point_y      <= cur_word.py;
                    point_z      <= cur_word.pz;
                    in_valid     <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : watch_labels
        label_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (label_queue.size() == 0) begin
                    $error("unexpected word: nearest_plane=%0d labeled=%0d best_distance=%0d",
                           nearest_plane, labeled, best_distance);
                    fails++;
                end else begin
                    want = label_queue.pop_front();
                    points_checked++;
                    if (labeled === 1'b1)
                        labeled_seen++;
                    if (nearest_plane !== want.plane) begin
                        $error("nearest_plane: expected %0d, got %0d", want.plane, nearest_plane);
                        fails++;
                    end
                    if (labeled !== want.hit) begin
                        $error("labeled: expected %0d, got %0d", want.hit, labeled);
                        fails++;
                    end
                    if (best_distance !== want.gap) begin
                        $error("best_distance: expected %0d, got %0d", want.gap, best_distance);
                        fails++;
                    end
                end
            end
            if (hold_served != hold_reqs) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [15:0] rnd_norm();
        int v;
        v = $urandom_range(0, 32768);
        return 16'(v - 16384);
    endfunction

    function automatic logic signed [31:0] small_coord();
        int v;
        v = $urandom_range(0, 1 << 20);
        return v - (1 << 19);
    endfunction

    function automatic word_t rand_word(logic cmd);
        word_t w;
        w.cmd = cmd;
        w.idx = 4'($urandom_range(0, PLANES - 1));
        w.nx = rnd_norm();
        w.ny = rnd_norm();
        w.nz = rnd_norm();
        w.ofs = $urandom;
        w.px = $urandom;
        w.py = $urandom;
        w.pz = $urandom;
        return w;
    endfunction

    function automatic void queue_word(word_t w);
        if (w.cmd == npl_pkg::CMD_LOAD)
            planned[w.idx] = w;
        pending = {pending, w};
    endfunction

    function automatic void queue_plane(int idx, int nx, int ny, int nz, logic [31:0] ofs);
        word_t w;
        w = rand_word(npl_pkg::CMD_LOAD);
        w.idx = 4'(idx);
        w.nx = 16'(nx);
        w.ny = 16'(ny);
        w.nz = 16'(nz);
        w.ofs = ofs;
        queue_word(w);
    endfunction

    function automatic void queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        word_t w;
        w = rand_word(npl_pkg::CMD_CLASSIFY);
        w.px = x;
        w.py = y;
        w.pz = z;
        queue_word(w);
    endfunction

    function automatic logic signed [31:0] near_coord(logic signed [15:0] n,
                                                      logic signed [31:0] ofs);
        int noise;
        noise = $urandom_range(0, 16000);
        return ((n > 0) ? -ofs : ofs) + noise - 8000;
    endfunction

    function automatic void fill_random(int count);
        word_t w;
        word_t p;
        int eff;
        int mode;
        int sgn;
        eff = (int'(cfg_count) > PLANES) ? PLANES : int'(cfg_count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 20) begin
                w = rand_word(npl_pkg::CMD_LOAD);
                if ($urandom_range(0, 1) == 1) begin
                    sgn = $urandom_range(0, 1) ? -16384 : 16384;
                    w.nx = '0;
                    w.ny = '0;
                    w.nz = '0;
                    case ($urandom_range(0, 2))
                        0: w.nx = 16'(sgn);
                        1: w.ny = 16'(sgn);
                        default: w.nz = 16'(sgn);
                    endcase
                end
                if ($urandom_range(0, 1) == 1)
                    w.ofs = small_coord();
            end else begin
                w = rand_word(npl_pkg::CMD_CLASSIFY);
                mode = $urandom_range(0, 9);
                if (mode < 8) begin
                    w.px = small_coord();
                    w.py = small_coord();
                    w.pz = small_coord();
                end
                if (mode < 5 && eff > 0) begin
                    p = planned[4'($urandom_range(0, eff - 1))];
                    if (p.ny == 0 && p.nz == 0 && (p.nx == 16384 || p.nx == -16384))
                        w.px = near_coord(p.nx, p.ofs);
                    else if (p.nx == 0 && p.nz == 0 && (p.ny == 16384 || p.ny == -16384))
                        w.py = near_coord(p.ny, p.ofs);
                    else if (p.nx == 0 && p.ny == 0 && (p.nz == 16384 || p.nz == -16384))
                        w.pz = near_coord(p.nz, p.ofs);
                end
            end
            queue_word(w);
        end
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_valid || label_queue.size() != 0);
        repeat (32) @(posedge clk);
    endtask

    task automatic set_config(input logic [npl_pkg::DIST_W-1:0] count,
                              input logic [npl_pkg::DIST_W-1:0] limit);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= npl_pkg::REG_PLANE_COUNT;
        wr_data <= count;
        @(posedge clk);
        wr_index <= npl_pkg::REG_DISTANCE_LIMIT;
        wr_data <= limit;
        @(posedge clk);
        wr_en <= 1'b0;
        cfg_count = count[npl_pkg::CNT_W-1:0];
        cfg_limit = limit;
        settings_run++;
        @(negedge clk);
    endtask

    initial begin : run_phases
        int unsigned phase_count[8];
        logic [npl_pkg::DIST_W-1:0] phase_limit[8];
        phase_count = '{16, 1, 16, 0, 8, 17, 31, 16};
        phase_limit = '{npl_pkg::LIMIT_RESET, 31'd0, npl_pkg::DIST_MAX, npl_pkg::DIST_MAX,
                        31'd0, 31'd65536, 31'd6553, npl_pkg::LIMIT_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no planes selected after reset
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // oversized count, zero limit: fill every entry, then extremes, ties, rounding
        set_config(31'd31, 31'd0);
        queue_plane(0, 16384, 0, 0, 32'h0);
        queue_plane(1, 0, 16384, 0, 32'h0);
        queue_plane(2, -16384, -16384, -16384, 32'h8000_0000);
        queue_plane(3, 16384, 16384, 16384, 32'h7FFF_FFFF);
        queue_plane(4, 0, 0, -16384, 32'h0064_0000);
        for (int i = 5; i < PLANES; i++)
            queue_plane(i, int'(rnd_norm()), int'(rnd_norm()), int'(rnd_norm()), $urandom);
        queue_point(32'h0, 32'h0, 32'h0);
        queue_point(32'h0005_0000, 32'hFFFB_0000, 32'h0);
        queue_point(32'h0000_0001, 32'h0010_0000, 32'h0010_0000);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            if (ph == 4)
                phase_limit[3'(ph)] = 31'($urandom_range(0, 1 << 20));
            set_config(31'(phase_count[3'(ph)]), phase_limit[3'(ph)]);
            if (ph == 2)
                hold_reqs++;
            if (ph == 7)
                calm = 1'b1;
            fill_random(150);
        end
        wait_idle();

        $display("Summary: %0d words driven, %0d points checked, %0d labeled, %0d settings",
                 words_sent, points_checked, labeled_seen, settings_run);
        $display("Plane counts 0 to 31 and limits from zero to full scale, with back-pressure");
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/npl_pkg.sv
sv/npl_ram.sv
sv/npl_dist.sv
sv/nearest_plane_point_labeler.sv
dv/tb.sv
